// ===== sv/uvs_pkg.sv =====
package uvs_pkg;

  // CORDIC datapath: x, y in Q2.30 plus headroom, z in 2^-32 turn plus headroom
  localparam int XW = 34;
  localparam int QW = 17;
  localparam int DIV_STEPS = 16;
  localparam logic signed [XW-1:0] CORDIC_X0 = 34'sd652032874;

  // per-point side data carried down the pipe
  typedef struct packed {
    logic [15:0] vidx;
    logic        cell_ok;
    logic        point_ok;
  } meta_t;

  // arctangent of 2^-i in 2^-32 turn
  function automatic logic signed [XW-1:0] atan_turn(input int i);
    logic signed [XW-1:0] r;
    r = '0;
    case (i)
      0:  r = 34'sd536870912;
      1:  r = 34'sd316933406;
      2:  r = 34'sd167458907;
      3:  r = 34'sd85004756;
      4:  r = 34'sd42667331;
      5:  r = 34'sd21354465;
      6:  r = 34'sd10679838;
      7:  r = 34'sd5340245;
      8:  r = 34'sd2670163;
      9:  r = 34'sd1335087;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41722;
      15: r = 34'sd20861;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2608;
      19: r = 34'sd1304;
      20: r = 34'sd652;
      21: r = 34'sd326;
      22: r = 34'sd163;
      23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // saturate to the unit range of Q1.14
  function automatic logic signed [15:0] clamp_unit(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd16384) begin
      r = 16'sd16384;
    end else if (v < -20'sd16384) begin
      r = -16'sd16384;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/uv_sphere_vertex_generator.sv =====
// One grid point enters per cycle (start while busy is low; busy stays low) and
// its vertex leaves as a single-cycle done beat after it has passed the input
// register, the first quotient bit stage, the 16-step divider chain, the CORDIC
// chain of CORDIC_STAGES cells and five rounding and multiply stages. The
// receiver cannot stall, so every beat must be taken the cycle done is high.
// Configuration writes take effect at once and are to be made only with no
// point in flight.
module uv_sphere_vertex_generator import uvs_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         stack_row,
  input  logic [7:0]         slice_col,
  output logic               done,
  output logic signed [16:0] pos_x,
  output logic signed [16:0] pos_y,
  output logic signed [16:0] pos_z,
  output logic signed [15:0] norm_x,
  output logic signed [15:0] norm_y,
  output logic signed [15:0] norm_z,
  output logic [16:0]        tex_u,
  output logic [16:0]        tex_v,
  output logic [15:0]        vertex_index,
  output logic               cell_valid,
  output logic               point_valid
);

  localparam int N = CORDIC_STAGES;
  localparam int LAT = 23 + N;
  localparam int MD = 21 + N;
  localparam int TD = N + 4;
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_STACKS = 2'd1;
  localparam logic [1:0] REG_SLICES = 2'd2;

  logic [15:0] radius;
  logic [7:0]  stack_count;
  logic [7:0]  slice_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= 16'd256;
      stack_count <= 8'd16;
      slice_count <= 8'd32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIUS: radius      <= cfg_data;
        REG_STACKS: stack_count <= cfg_data[7:0];
        REG_SLICES: slice_count <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // beat valid shift line
  logic [LAT-2:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-3:0], start & ~busy};
    end
  end

  // input registers
  logic [7:0] row0, col0;
  always_ff @(posedge clk) begin
    row0 <= stack_row;
    col0 <= slice_col;
  end

  // first quotient bit, flags and vertex index
  logic [7:0]    rem_v [0:DIV_STEPS];
  logic [7:0]    rem_u [0:DIV_STEPS];
  logic [QW-1:0] quo_v [0:DIV_STEPS];
  logic [QW-1:0] quo_u [0:DIV_STEPS];
  meta_t         meta_d [0:MD-1];
  meta_t         meta_a;

  always_comb begin
    meta_a.point_ok = (stack_count != 8'd0) && (slice_count != 8'd0) &&
                      (row0 <= stack_count) && (col0 <= slice_count);
    meta_a.cell_ok  = (row0 < stack_count) && (col0 < slice_count);
    meta_a.vidx     = 16'({8'd0, row0} * ({8'd0, slice_count} + 16'd1) + {8'd0, col0});
  end

  always_ff @(posedge clk) begin
    quo_v[0]  <= {16'd0, row0 >= stack_count};
    rem_v[0]  <= (row0 >= stack_count) ? 8'(row0 - stack_count) : row0;
    quo_u[0]  <= {16'd0, col0 >= slice_count};
    rem_u[0]  <= (col0 >= slice_count) ? 8'(col0 - slice_count) : col0;
    meta_d[0] <= meta_a;
    for (int k = 1; k < MD; k++) begin
      meta_d[k] <= meta_d[k-1];
    end
  end

  // restoring divider chains for v and u
  genvar g;
  generate
    for (g = 0; g < DIV_STEPS; g++) begin : g_div
      uvs_div_cell u_dv (
        .clk(clk), .divisor(stack_count), .rem_in(rem_v[g]), .quo_in(quo_v[g]),
        .rem(rem_v[g+1]), .quo(quo_v[g+1])
      );
      uvs_div_cell u_du (
        .clk(clk), .divisor(slice_count), .rem_in(rem_u[g]), .quo_in(quo_u[g]),
        .rem(rem_u[g+1]), .quo(quo_u[g+1])
      );
    end
  endgenerate

  logic [QW-1:0] tu_d [0:TD-1];
  logic [QW-1:0] tv_d [0:TD-1];
  always_ff @(posedge clk) begin
    tu_d[0] <= quo_u[DIV_STEPS];
    tv_d[0] <= quo_v[DIV_STEPS];
    for (int k = 1; k < TD; k++) begin
      tu_d[k] <= tu_d[k-1];
      tv_d[k] <= tv_d[k-1];
    end
  end

  // fold angles into the right half plane
  logic [15:0] phi, theta, phi_f, theta_f;
  logic        phi_flip, theta_flip;
  assign phi        = quo_v[DIV_STEPS][16:1];
  assign theta      = quo_u[DIV_STEPS][15:0];
  assign phi_flip   = phi[15] ^ phi[14];
  assign theta_flip = theta[15] ^ theta[14];
  assign phi_f      = {phi[15] ^ phi_flip, phi[14:0]};
  assign theta_f    = {theta[15] ^ theta_flip, theta[14:0]};

  logic signed [XW-1:0] px [0:N], py [0:N], pz [0:N];
  logic signed [XW-1:0] tx [0:N], ty [0:N], tz [0:N];
  logic                 pf [0:N], tf [0:N];

  assign px[0] = CORDIC_X0;
  assign py[0] = '0;
  assign pz[0] = XW'($signed({phi_f, 16'd0}));
  assign pf[0] = phi_flip;
  assign tx[0] = CORDIC_X0;
  assign ty[0] = '0;
  assign tz[0] = XW'($signed({theta_f, 16'd0}));
  assign tf[0] = theta_flip;

  // CORDIC chains for phi and theta
  generate
    for (g = 0; g < N; g++) begin : g_cordic
      uvs_cordic_cell #(.STAGE(g)) u_cp (
        .clk(clk), .x_in(px[g]), .y_in(py[g]), .z_in(pz[g]), .flip_in(pf[g]),
        .x(px[g+1]), .y(py[g+1]), .z(pz[g+1]), .flip(pf[g+1])
      );
      uvs_cordic_cell #(.STAGE(g)) u_ct (
        .clk(clk), .x_in(tx[g]), .y_in(ty[g]), .z_in(tz[g]), .flip_in(tf[g]),
        .x(tx[g+1]), .y(ty[g+1]), .z(tz[g+1]), .flip(tf[g+1])
      );
    end
  endgenerate

  // round sin and cos to Q1.14, clamp, undo the fold
  logic signed [XW-1:0] rpx, rpy, rtx, rty;
  logic signed [15:0]   sp, cp, st, ct;
  logic signed [15:0]   sp_c, cp_c, st_c, ct_c;
  assign rpx  = (px[N] + XW'(32768)) >>> 16;
  assign rpy  = (py[N] + XW'(32768)) >>> 16;
  assign rtx  = (tx[N] + XW'(32768)) >>> 16;
  assign rty  = (ty[N] + XW'(32768)) >>> 16;
  assign cp_c = clamp_unit(20'(rpx));
  assign sp_c = clamp_unit(20'(rpy));
  assign ct_c = clamp_unit(20'(rtx));
  assign st_c = clamp_unit(20'(rty));

  always_ff @(posedge clk) begin
    sp <= pf[N] ? -sp_c : sp_c;
    cp <= pf[N] ? -cp_c : cp_c;
    st <= tf[N] ? -st_c : st_c;
    ct <= tf[N] ? -ct_c : ct_c;
  end

  // normal products
  logic signed [31:0] prod_x, prod_z;
  logic signed [15:0] ny2;
  always_ff @(posedge clk) begin
    prod_x <= sp * ct;
    prod_z <= sp * st;
    ny2    <= cp;
  end

  // round normals
  logic signed [15:0] nx3, ny3, nz3;
  logic signed [31:0] rnx, rnz;
  assign rnx = (prod_x + 32'sd8192) >>> 14;
  assign rnz = (prod_z + 32'sd8192) >>> 14;
  always_ff @(posedge clk) begin
    nx3 <= clamp_unit(20'(rnx));
    nz3 <= clamp_unit(20'(rnz));
    ny3 <= ny2;
  end

  // scale by radius
  logic signed [16:0] rad_s;
  logic signed [32:0] qx, qy, qz;
  logic signed [15:0] nx4, ny4, nz4;
  assign rad_s = $signed({1'b0, radius});
  always_ff @(posedge clk) begin
    qx  <= nx3 * rad_s;
    qy  <= ny3 * rad_s;
    qz  <= nz3 * rad_s;
    nx4 <= nx3;
    ny4 <= ny3;
    nz4 <= nz3;
  end

  // round positions, zero points off the grid, drive the result beat
  logic signed [32:0] rqx, rqy, rqz;
  meta_t              m4;
  assign rqx = (qx + 33'sd8192) >>> 14;
  assign rqy = (qy + 33'sd8192) >>> 14;
  assign rqz = (qz + 33'sd8192) >>> 14;
  assign m4  = meta_d[MD-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[LAT-2];
    end
    pos_x        <= m4.point_ok ? rqx[16:0] : '0;
    pos_y        <= m4.point_ok ? rqy[16:0] : '0;
    pos_z        <= m4.point_ok ? rqz[16:0] : '0;
    norm_x       <= m4.point_ok ? nx4 : '0;
    norm_y       <= m4.point_ok ? ny4 : '0;
    norm_z       <= m4.point_ok ? nz4 : '0;
    tex_u        <= m4.point_ok ? tu_d[TD-1] : '0;
    tex_v        <= m4.point_ok ? tv_d[TD-1] : '0;
    vertex_index <= m4.point_ok ? m4.vidx : '0;
    cell_valid   <= m4.point_ok & m4.cell_ok;
    point_valid  <= m4.point_ok;
  end

endmodule

// ===== sv/uvs_div_cell.sv =====
module uvs_div_cell import uvs_pkg::*; (
  input  logic          clk,
  input  logic [7:0]    divisor,
  input  logic [7:0]    rem_in,
  input  logic [QW-1:0] quo_in,
  output logic [7:0]    rem,
  output logic [QW-1:0] quo
);

  logic [8:0] r2;
  logic       ge;

  // shift in a zero dividend bit, try to subtract
  assign r2 = {rem_in, 1'b0};
  assign ge = (r2 >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    rem <= ge ? 8'(r2 - {1'b0, divisor}) : r2[7:0];
    quo <= {quo_in[QW-2:0], ge};
  end

endmodule

// ===== sv/uvs_cordic_cell.sv =====
module uvs_cordic_cell import uvs_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic                 clk,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [XW-1:0] z_in,
  input  logic                 flip_in,
  output logic signed [XW-1:0] x,
  output logic signed [XW-1:0] y,
  output logic signed [XW-1:0] z,
  output logic                 flip
);

  localparam logic signed [XW-1:0] ATAN = atan_turn(STAGE);

  // rotate toward zero residual angle
  always_ff @(posedge clk) begin
    if (!z_in[XW-1]) begin
      x <= x_in - (y_in >>> STAGE);
      y <= y_in + (x_in >>> STAGE);
      z <= z_in - ATAN;
    end else begin
      x <= x_in + (y_in >>> STAGE);
      y <= y_in - (x_in >>> STAGE);
      z <= z_in + ATAN;
    end
    flip <= flip_in;
  end

endmodule
